>>> rtl/core/obbct_pkg.sv
// Package for the oriented-box overlap and contact tracker.
// Shared constants, event codes and the dot-magnitude helper; no dependencies.
package obbct_pkg;

  localparam int DefPairSlots = 1024;
  localparam int SlotW        = 10;
  localparam int ValW         = 32;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  // Result of the overlap test, handed from the test unit to the tracker.
  typedef struct packed {
    logic             overlap;
    logic [SlotW-1:0] slot;
  } ovl_req_t;

  // Saturated magnitude of the sum of two signed 64-bit products.
  function automatic logic [63:0] sum_mag(input logic signed [63:0] m1,
                                          input logic signed [63:0] m2);
    logic signed [64:0] s;
    logic [64:0]        a;
    begin
      s = {m1[63], m1} + {m2[63], m2};
      a = s[64] ? 65'(-s) : 65'(s);
      sum_mag = (a > 65'h0_7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : a[63:0];
    end
  endfunction

endpackage

>>> rtl/core/obb_overlap_contact_tracker.sv
// Oriented-box overlap test with per-pair contact tracking; top level.
// Depends on obbct_pkg, obbct_sat_test and obbct_tracker.
//
// One request at a time: the next item is not accepted until the result of the
// last has been taken. The single shared pair of 32x32 multipliers forms five
// dot products for each nonzero axis, while a zero axis is skipped; the test
// stops at the first separating axis. Then come the test's finish, the
// touching-bit read and write-back, presenting the result and a return to idle
// before the next request. After reset a clearing pass zeroes all PAIR_SLOTS
// entries of the touching-bit memory before the first request.
module obb_overlap_contact_tracker
  import obbct_pkg::*;
#(
  parameter int PAIR_SLOTS = DefPairSlots
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: first_edge_x_x, first_edge_x_y, first_edge_y_x, first_edge_y_y,
  // second_edge_x_x, second_edge_x_y, second_edge_y_x, second_edge_y_y,
  // center_offset_x, center_offset_y, shape_pair, pair_slot, zero fill
  input  logic [335:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: overlap, contact_event, zero fill
  output logic [7:0]   out_tdata
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TEST = 2'd1;
  localparam logic [1:0] PH_TRK  = 2'd2;
  localparam logic [1:0] PH_OUT  = 2'd3;

  logic [1:0]       ph_r;
  logic [SlotW-1:0] slot_r;
  logic             ovl_r;
  logic [1:0]       ev_r;
  logic             accept, t_done, t_ovl, clearing, k_done;
  logic [1:0]       k_ev;
  ovl_req_t         req;

  assign in_tready  = (ph_r == PH_IDLE) && !clearing;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (ph_r == PH_OUT);
  assign out_tdata  = {5'd0, ev_r, ovl_r};
  assign req.overlap = t_ovl;
  assign req.slot    = slot_r;

  obbct_sat_test u_test (
    .clk(clk), .rst_n(rst_n), .start(accept),
    .edges(in_tdata[255:0]), .cen(in_tdata[319:256]),
    .shape_pair(in_tdata[321:320]),
    .done(t_done), .overlap(t_ovl)
  );

  obbct_tracker #(.PAIR_SLOTS(PAIR_SLOTS)) u_trk (
    .clk(clk), .rst_n(rst_n), .req_valid(t_done), .req(req),
    .clearing(clearing), .done(k_done), .event_code(k_ev)
  );

  // Request sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      unique case (ph_r)
        PH_IDLE: if (accept) ph_r <= PH_TEST;
        PH_TEST: if (t_done) ph_r <= PH_TRK;
        PH_TRK:  if (k_done) ph_r <= PH_OUT;
        PH_OUT:  if (out_tready) ph_r <= PH_IDLE;
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) slot_r <= in_tdata[331:322];
    if (t_done) ovl_r <= t_ovl;
    if (k_done) ev_r <= k_ev;
  end

endmodule

>>> rtl/core/obbct_sat_test.sv
// Four-axis separating-axis test on one shared product pair, one box pair at a time.
// Depends on obbct_pkg.
module obbct_sat_test
  import obbct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [8*ValW-1:0]      edges,
  input  logic [2*ValW-1:0]      cen,
  input  logic [1:0]             shape_pair,
  output logic                   done,
  output logic                   overlap
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [ValW-1:0]  sx_r [4];
  logic signed [ValW-1:0]  sy_r [4];
  logic signed [ValW-1:0]  cx_r, cy_r;
  logic [1:0]              ai_r, aj_r;
  logic                    cterm_r;
  logic signed [63:0]      m1_r, m2_r;
  logic [64:0]             sum_r;
  logic                    ovl_r, acc_c_r;
  logic signed [ValW-1:0]  ox, oy;
  logic [63:0]             mag;
  logic [64:0]             sum_add;
  logic                    zero_axis;

  // Half of p plus q, formed one bit wider; used for the diamond transform of the edge vectors.
  function automatic logic signed [ValW-1:0] hsum(input logic signed [ValW-1:0] p,
                                                  input logic signed [ValW-1:0] q);
    logic signed [ValW:0] t;
    begin
      t = {p[ValW-1], p} + {q[ValW-1], q};
      hsum = t[ValW:1];
    end
  endfunction

  // Half of p minus q, formed one bit wider so the most negative value is exact.
  function automatic logic signed [ValW-1:0] hdiff(input logic signed [ValW-1:0] p,
                                                   input logic signed [ValW-1:0] q);
    logic signed [ValW:0] t;
    begin
      t = {p[ValW-1], p} - {q[ValW-1], q};
      hdiff = t[ValW:1];
    end
  endfunction

  assign done    = (state_r == ST_DONE);
  assign overlap = ovl_r;
  assign zero_axis = (sx_r[ai_r] == '0) && (sy_r[ai_r] == '0);
  assign ox = cterm_r ? cx_r : sx_r[aj_r];
  assign oy = cterm_r ? cy_r : sy_r[aj_r];
  assign mag = sum_mag(m1_r, m2_r);
  assign sum_add = sum_r + {1'b0, mag};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = zero_axis ? ((ai_r == 2'd3) ? ST_DONE : ST_MUL) : ST_ACC;
      ST_ACC:  begin
        if (acc_c_r) begin
          if (({1'b0, mag, 1'b0} >= {1'b0, sum_r}) || (ai_r == 2'd3)) state_nxt = ST_DONE;
          else state_nxt = ST_MUL;
        end else state_nxt = ST_MUL;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: load, multiply, accumulate and compare.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      for (int k = 0; k < 2; k++) begin
        logic signed [ValW-1:0] ax, ay, bx, by;
        logic dia;
        ax = edges[(4*k)*ValW +: ValW];
        ay = edges[(4*k+1)*ValW +: ValW];
        bx = edges[(4*k+2)*ValW +: ValW];
        by = edges[(4*k+3)*ValW +: ValW];
        dia = (k == 0) ? shape_pair[0] : (shape_pair == 2'd1 || shape_pair == 2'd2);
        sx_r[2*k]   <= dia ? hsum(ax, bx) : ax;
        sy_r[2*k]   <= dia ? hsum(ay, by) : ay;
        sx_r[2*k+1] <= dia ? hdiff(bx, ax) : bx;
        sy_r[2*k+1] <= dia ? hdiff(by, ay) : by;
      end
      cx_r <= cen[ValW-1:0];
      cy_r <= cen[2*ValW-1:ValW];
      ai_r <= 2'd0; aj_r <= 2'd0; cterm_r <= 1'b0;
      sum_r <= '0; ovl_r <= 1'b1;
    end else if (state_r == ST_MUL) begin
      if (zero_axis) begin
        ai_r <= ai_r + 2'd1;
        aj_r <= 2'd0; cterm_r <= 1'b0; sum_r <= '0;
      end else begin
        m1_r <= 64'(ox) * 64'(sx_r[ai_r]);
        m2_r <= 64'(oy) * 64'(sy_r[ai_r]);
        acc_c_r <= cterm_r;
      end
    end else if (state_r == ST_ACC) begin
      if (acc_c_r) begin
        if ({1'b0, mag, 1'b0} >= {1'b0, sum_r}) ovl_r <= 1'b0;
        ai_r <= ai_r + 2'd1; aj_r <= 2'd0; cterm_r <= 1'b0; sum_r <= '0;
      end else begin
        sum_r <= sum_add[64] ? 65'h0_FFFF_FFFF_FFFF_FFFF : sum_add;
        if (aj_r == 2'd3) cterm_r <= 1'b1;
        aj_r <= aj_r + 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/obbct_tracker.sv
// Per-slot touching-bit store with clearing pass and read-modify-write.
// Depends on obbct_pkg.
module obbct_tracker
  import obbct_pkg::*;
#(
  parameter int PAIR_SLOTS = DefPairSlots
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  ovl_req_t   req,
  output logic       clearing,
  output logic       done,
  output logic [1:0] event_code
);

  localparam int AW = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;

  logic          mem [PAIR_SLOTS];
  logic [AW:0]   clr_r;
  logic          rd_r;
  logic          rd_bit_r;
  logic          ovl_r, inr_r;
  logic [AW-1:0] addr_r;
  logic          in_range;

  assign clearing = (clr_r != (AW+1)'(PAIR_SLOTS));
  assign in_range = ({{(32-SlotW){1'b0}}, req.slot} < 32'(PAIR_SLOTS));
  assign done = rd_r;

  always_comb begin
    event_code = EV_NONE;
    if (inr_r) begin
      if (ovl_r) event_code = rd_bit_r ? EV_STAY : EV_ENTER;
      else if (rd_bit_r) event_code = EV_EXIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      rd_r <= req_valid && !clearing;
      if (clearing) clr_r <= clr_r + (AW+1)'(1);
    end
  end

  // Read stage, then write-back of the new bit.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_r[AW-1:0]] <= 1'b0;
    end else if (rd_r && inr_r) begin
      mem[addr_r] <= ovl_r;
    end
    if (req_valid) begin
      rd_bit_r <= mem[AW'(req.slot)];
      addr_r   <= AW'(req.slot);
      ovl_r    <= req.overlap;
      inr_r    <= in_range;
    end
  end

endmodule
